// File: design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Types, constants and helpers for the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int IN_VALUE_W     = 32;
   localparam int RADIX_W        = 6;
   localparam int DIGIT_W        = 6;
   localparam int CHAR_W         = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC   = 6'd9;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO       = 8'h30; // '0'
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE = 8'h57; // 'a' - 10
   localparam logic [CHAR_W-1:0]  CHAR_MINUS      = 8'h2d; // '-'

   typedef struct packed {
      logic [IN_VALUE_W-1:0] value;
      logic [RADIX_W-1:0]    radix;
      logic                  opcode;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_LOAD,
      ST_HOLD
   } itoa_state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] base;
      base = (d <= DIGIT_MAX_DEC) ? CHAR_ZERO : CHAR_ALPHA_BASE;
      return base + {{(CHAR_W-DIGIT_W){1'b0}}, d};
   endfunction

endpackage

// File: design/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a binary value to ASCII digits in radix 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data) takes value, radix and
//   opcode. req_stall is high from acceptance until the last character has
//   been taken, so one number is converted at a time. A radix outside 2..36
//   is taken and dropped without any response.
//   Response channel (rsp_valid / rsp_stall / rsp_data) delivers one
//   character per transfer, most significant digit first, with last set on
//   the final one. A negative value in signed radix ten gets a leading '-'.
//   Each digit costs one pass of the bit-serial divider, and all digits are
//   computed before the first character is sent. After that each character
//   is read from the digit memory into the output register once the one
//   before it has been taken.
//   While rsp_stall is high the current character is held in the output
//   register and the block waits. Reset clears the sequencer and the output
//   valid; the digit memory needs no clearing.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  itoa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   localparam int ADDR_W  = $clog2(VALUE_BITS);
   localparam int COUNT_W = $clog2(VALUE_BITS + 1);

   itoa_state_type        state_ff, state_in;
   logic [VALUE_BITS-1:0] quotient_ff, quotient_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  minus_ff, minus_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  div_start;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [DIGIT_W-1:0]    div_remainder;

   logic                  wr_en;
   logic                  rd_en;
   logic [DIGIT_W-1:0]    rd_data;

   logic                  req_take;
   logic                  rsp_take;
   logic                  radix_ok;
   logic [VALUE_BITS-1:0] in_value;
   logic                  in_neg;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign radix_ok = (req_data.radix >= RADIX_MIN) && (req_data.radix <= RADIX_MAX);
   assign in_value = VALUE_BITS'(req_data.value);
   assign in_neg   = (req_data.opcode == OP_SIGNED) && (req_data.radix == RADIX_DEC)
                     && in_value[VALUE_BITS-1];

   always_comb begin
      state_in     = state_ff;
      quotient_in  = quotient_ff;
      count_in     = count_ff;
      minus_in     = minus_ff;
      radix_in     = radix_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && radix_ok) begin
               quotient_in = in_neg ? (~in_value + 1'b1) : in_value;
               minus_in    = in_neg;
               radix_in    = req_data.radix;
               count_in    = '0;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               wr_en       = (count_ff < COUNT_W'(VALUE_BITS));
               count_in    = wr_en ? count_ff + 1'b1 : count_ff;
               quotient_in = div_quotient;
               if (div_quotient != '0) begin
                  state_in = ST_START;
               end else if (minus_ff) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SIGN: begin
            rsp_data_in.out_char = CHAR_MINUS;
            rsp_data_in.last     = 1'b0;
            rsp_valid_in         = 1'b1;
            state_in             = ST_HOLD;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_data_in.out_char = digit_char(rd_data);
            rsp_data_in.last     = (count_ff == COUNT_W'(1));
            rsp_valid_in         = 1'b1;
            count_in             = count_ff - 1'b1;
            state_in             = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               state_in     = (count_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         minus_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         quotient_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         minus_ff     <= minus_in;
         rsp_valid_ff <= rsp_valid_in;
         quotient_ff  <= quotient_in;
      end
      radix_ff    <= radix_in;
      rsp_data_ff <= rsp_data_in;
   end

   itoa_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (quotient_ff),
      .divisor  (radix_ff),
      .done     (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   itoa_store #(
      .VALUE_BITS(VALUE_BITS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(div_remainder),
      .rd_en  (rd_en),
      .rd_addr(ADDR_W'(count_ff - 1'b1)),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/itoa_div.sv
// ----------------------------------------------------------------------------
// itoa_div
// Restoring divider: one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module itoa_div #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [VALUE_BITS-1:0]        dividend,
   input  logic [itoa_pkg::RADIX_W-1:0] divisor,
   output logic                         done,
   output logic [VALUE_BITS-1:0]        quotient,
   output logic [itoa_pkg::DIGIT_W-1:0] remainder
);
   import itoa_pkg::*;

   localparam int STEP_W = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [VALUE_BITS-1:0] work_ff, work_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [RADIX_W-1:0]    div_ff, div_in;

   logic [DIGIT_W:0] trial;
   logic [DIGIT_W:0] diff;
   logic             ge;

   assign trial = {rem_ff, work_ff[VALUE_BITS-1]};
   assign ge    = (trial >= {1'b0, div_ff});
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         work_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits DIGIT_W bits
         work_in = {work_ff[VALUE_BITS-2:0], ge};
         rem_in  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

// File: design/itoa_store.sv
// ----------------------------------------------------------------------------
// itoa_store
// Digit memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itoa_store #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(VALUE_BITS)-1:0] wr_addr,
   input  logic [itoa_pkg::DIGIT_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(VALUE_BITS)-1:0] rd_addr,
   output logic [itoa_pkg::DIGIT_W-1:0]  rd_data
);
   import itoa_pkg::*;

   logic [DIGIT_W-1:0] digit_mem [VALUE_BITS];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/itoa_check.sv
// ----------------------------------------------------------------------------
// itoa_check
// Port-level checks for the integer to ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itoa_check (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   // hold a stalled response
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // never take a request while a character is pending
   `ASSERT_IMP(a_busy_on_rsp, clock, reset, rsp_valid, req_stall)
   // more characters follow a non-last one, so stay busy
   `ASSERT_NXT(a_busy_after_mid, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last, req_stall)
   // reset drops the response valid
   `ASSERT_NXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind integer_to_ascii_radix itoa_check u_itoa_check (.*);

// File: verif/integer_to_ascii_radix_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_tb
// Self-checking bench for the radix converter. It sends value/radix/opcode
// requests with random gaps and back-pressure on the character stream. It
// predicts the character string of each accepted request and checks every
// character and last flag in order.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_tb;
   import itoa_pkg::*;

   localparam int RANDOM_REQS   = 72;
   localparam int TAIL_REQS     = 12;
   localparam int HOLD_CYCLES   = 1500;
   localparam int WATCHDOG_MAX  = 20000;
   localparam int DRAIN_CYCLES  = 200;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_reqs [$];
   rsp_type expected_chars [$];

   int  error_count  = 0;
   int  chars_seen   = 0;
   int  gap_left     = 0;
   int  stall_left   = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   bit  req_taken    = 1'b0;
   bit  any_taken    = 1'b0;
   int  quiet_cycles = 0;

   integer_to_ascii_radix u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // build the character string that one request should produce
   function automatic void predict_chars(input req_type item);
      logic [IN_VALUE_W-1:0] q;
      logic [IN_VALUE_W-1:0] base;
      logic [DIGIT_W-1:0]    d;
      logic [DIGIT_W-1:0]    digits [$];
      rsp_type               c;
      bit                    negative;
      if (item.radix < RADIX_MIN || item.radix > RADIX_MAX) begin
         return;
      end
      base = {{(IN_VALUE_W-RADIX_W){1'b0}}, item.radix};
      q = item.value;
      negative = (item.opcode == OP_SIGNED) && (item.radix == RADIX_DEC) && q[IN_VALUE_W-1];
      if (negative) begin
         q = -q;
         c.out_char = CHAR_MINUS;
         c.last = 1'b0;
         expected_chars.push_back(c);
      end
      do begin
         d = DIGIT_W'(q % base);
         digits.push_front(d);
         q = q / base;
      end while (q != 0);
      for (int i = 0; i < digits.size(); i++) begin
         if (digits[i] <= DIGIT_MAX_DEC) begin
            c.out_char = CHAR_ZERO + {2'b00, digits[i]};
         end else begin
            c.out_char = CHAR_ALPHA_BASE + {2'b00, digits[i]};
         end
         c.last = (i == digits.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   function automatic req_type make_req(input logic [IN_VALUE_W-1:0] v,
                                        input logic [RADIX_W-1:0] r, input logic op);
      req_type item;
      item.value = v;
      item.radix = r;
      item.opcode = op;
      return item;
   endfunction

   // monitor: record accepted requests, check accepted characters
   always @(posedge clock) begin
      rsp_type want;
      req_taken = 1'b0;
      any_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            any_taken = 1'b1;
            predict_chars(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            any_taken = 1'b1;
            chars_seen++;
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected char", {24'd0, rsp_data.out_char}, 32'd0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  report_mismatch("out_char", {24'd0, rsp_data.out_char},
                                  {24'd0, want.out_char});
               end
               if (rsp_data.last !== want.last) begin
                  report_mismatch("last", {31'd0, rsp_data.last}, {31'd0, want.last});
               end
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || any_taken) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_MAX);
         $display("** integer_to_ascii_radix: FAILED **");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled request
      end else if (gap_left != 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() > TAIL_REQS && $urandom_range(0, 5) == 0) begin
         gap_left <= $urandom_range(0, 17);
         req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
         req_data <= pending_reqs.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // character receiver: short stall bursts plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && chars_seen >= 40) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (pending_reqs.size() > TAIL_REQS && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      logic [IN_VALUE_W-1:0] v;
      logic [RADIX_W-1:0]    r;
      logic                  op;
      int                    accepted_reqs;

      // zero, extremes, sign handling, digit/letter boundaries, invalid radices
      pending_reqs.push_back(make_req(32'd0, 6'd10, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'd0, RADIX_MIN, OP_SIGNED));
      pending_reqs.push_back(make_req(32'd1, RADIX_MIN, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'hffff_ffff, RADIX_MIN, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'hffff_ffff, RADIX_DEC, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'hffff_ffff, RADIX_DEC, OP_SIGNED));
      pending_reqs.push_back(make_req(32'h8000_0000, RADIX_DEC, OP_SIGNED));
      pending_reqs.push_back(make_req(32'h7fff_ffff, RADIX_DEC, OP_SIGNED));
      pending_reqs.push_back(make_req(32'h8000_0000, 6'd8, OP_SIGNED));
      pending_reqs.push_back(make_req(32'hffff_ffff, 6'd16, OP_SIGNED));
      pending_reqs.push_back(make_req(32'hffff_ffff, RADIX_MAX, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'd35, RADIX_MAX, OP_SIGNED));
      pending_reqs.push_back(make_req(32'd9, RADIX_DEC, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'd10, 6'd16, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'd12345, 6'd3, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'h1234_5678, 6'd0, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'h1234_5678, 6'd1, OP_SIGNED));
      pending_reqs.push_back(make_req(32'd99, 6'd37, OP_UNSIGNED));
      pending_reqs.push_back(make_req(32'hffff_ffff, 6'd63, OP_SIGNED));
      pending_reqs.push_back(make_req(32'd36, RADIX_MAX, OP_UNSIGNED));

      accepted_reqs = 0;
      while (accepted_reqs < RANDOM_REQS) begin
         case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(0, 40);
            2:       v = 32'hffff_ffff - $urandom_range(0, 40);
            3:       v = 32'h8000_0000 + $urandom_range(0, 40) - 20;
            default: v = $urandom;
         endcase
         case ($urandom_range(0, 9))
            0:       r = ($urandom_range(0, 1) == 0) ? RADIX_W'($urandom_range(0, 1))
                                                     : RADIX_W'($urandom_range(37, 63));
            1, 2:    r = RADIX_DEC;
            3:       r = RADIX_MAX - RADIX_W'($urandom_range(0, 4));
            default: r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
         endcase
         op = ($urandom_range(0, 1) == 1);
         pending_reqs.push_back(make_req(v, r, op));
         if (r >= RADIX_MIN && r <= RADIX_MAX) begin
            accepted_reqs++;
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_chars.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** integer_to_ascii_radix: PASSED **");
      end else begin
         $display("** integer_to_ascii_radix: FAILED **");
      end
      $finish;
   end

endmodule
